@@ src/motion_to_tap_accumulator_macros.svh @@
// Assertion helpers used by the checker of this block.
`ifndef MOTION_TO_TAP_ACCUMULATOR_MACROS_SVH
`define MOTION_TO_TAP_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on aclk, idle while in reset.
`define MTTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, idle while in reset.
`define MTTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mtta_pkg.sv @@
`timescale 1ns / 1ps

package mtta_pkg;

    localparam int MAX_AXES  = 4;
    localparam int AXIS_W    = 2;
    localparam int CNT_W     = 3;   // width of axis_count register
    localparam int IDX_W     = 3;   // width of configuration index
    localparam int MAG_W     = 17;  // |accumulator + motion| fits here
    localparam int ACC_W     = 17;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = 5;

    localparam logic [IDX_W-1:0] REG_MATCH_TYPE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_TAP_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_AXIS_COUNT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_AXIS_CODE_0   = 3'd3;
    localparam logic [IDX_W-1:0] REG_AXIS_CODE_1   = 3'd4;
    localparam logic [IDX_W-1:0] REG_AXIS_CODE_2   = 3'd5;
    localparam logic [IDX_W-1:0] REG_AXIS_CODE_3   = 3'd6;

    localparam logic [15:0] MATCH_TYPE_RST = 16'd2;
    localparam logic [15:0] THRESHOLD_RST  = 16'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic lookup;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/mtta_ctrl.sv @@
`timescale 1ns / 1ps

module mtta_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtta_pkg::dp_status_t status,
    output mtta_pkg::ctrl_cmd_t  cmd
);

    mtta_pkg::state_t state_reg;
    mtta_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtta_pkg::ST_IDLE: begin
                if (s_valid) state_next = mtta_pkg::ST_LOOKUP;
            end
            mtta_pkg::ST_LOOKUP: begin
                state_next = status.hit ? mtta_pkg::ST_DIVIDE : mtta_pkg::ST_DONE;
            end
            mtta_pkg::ST_DIVIDE: begin
                if (status.div_last) state_next = mtta_pkg::ST_DONE;
            end
            mtta_pkg::ST_DONE: begin
                if (status.out_free) state_next = mtta_pkg::ST_IDLE;
            end
            default: state_next = mtta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mtta_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            mtta_pkg::ST_LOOKUP: cmd.lookup   = 1'b1;
            mtta_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            mtta_pkg::ST_DONE:   cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

@@ src/mtta_dp.sv @@
`timescale 1ns / 1ps

module mtta_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [mtta_pkg::IDX_W-1:0]   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic [15:0]                  s_event_type,
    input  logic [15:0]                  s_event_code,
    input  logic signed [15:0]           s_motion,
    input  logic [7:0]                   s_source_device,
    input  mtta_pkg::ctrl_cmd_t          cmd,
    output mtta_pkg::dp_status_t         status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_consumed,
    output logic signed [15:0]           m_out_motion,
    output logic [2:0]                   m_binding_index,
    output logic [15:0]                  m_tap_count,
    output logic [7:0]                   m_tap_device
);

    // configuration
    logic [15:0]                match_type_reg;
    logic [15:0]                threshold_reg;
    logic [mtta_pkg::CNT_W-1:0] axis_count_reg;
    logic [15:0]                axis_code_reg [mtta_pkg::MAX_AXES];

    // per-axis state
    logic signed [mtta_pkg::ACC_W-1:0] acc_reg [mtta_pkg::MAX_AXES];

    // captured beat
    logic [15:0]        type_reg;
    logic [15:0]        code_reg;
    logic signed [15:0] motion_reg;
    logic [7:0]         dev_reg;

    // divider and bookkeeping
    logic                              hit_reg;
    logic [mtta_pkg::AXIS_W-1:0]       axis_reg;
    logic                              pos_reg;
    logic [15:0]                       t_reg;
    logic [mtta_pkg::MAG_W-1:0]        dvd_reg;
    logic [15:0]                       rem_reg;
    logic [mtta_pkg::STEP_W-1:0]       step_reg;

    logic                              m_valid_reg;
    logic                              consumed_reg;
    logic signed [15:0]                out_motion_reg;
    logic [2:0]                        binding_reg;
    logic [15:0]                       tap_count_reg;
    logic [7:0]                        tap_dev_reg;

    // lookup
    logic [mtta_pkg::CNT_W-1:0]        limit;
    logic                              hit;
    logic [mtta_pkg::AXIS_W-1:0]       axis;
    logic signed [mtta_pkg::ACC_W:0]   sum;
    logic                              pos;
    logic [mtta_pkg::MAG_W-1:0]        mag;

    // divider step
    logic [16:0] trial;
    logic        ge;
    logic [16:0] trial_diff;

    logic [15:0]                       q_sat;
    logic signed [mtta_pkg::ACC_W-1:0] acc_new;

    always_comb begin
        limit = (axis_count_reg > mtta_pkg::CNT_W'(mtta_pkg::MAX_AXES))
              ? mtta_pkg::CNT_W'(mtta_pkg::MAX_AXES) : axis_count_reg;
        hit  = 1'b0;
        axis = '0;
        // descending so the lowest matching axis wins
        for (int a = mtta_pkg::MAX_AXES - 1; a >= 0; a--) begin
            if ((mtta_pkg::CNT_W'(a) < limit) && (axis_code_reg[a] == code_reg)
                && (type_reg == match_type_reg)) begin
                hit  = 1'b1;
                axis = mtta_pkg::AXIS_W'(a);
            end
        end
        sum = (mtta_pkg::ACC_W+1)'(acc_reg[axis]) + (mtta_pkg::ACC_W+1)'(motion_reg);
        pos = (sum > 0);
        mag = pos ? sum[mtta_pkg::MAG_W-1:0] : mtta_pkg::MAG_W'(-sum);
    end

    assign trial      = {rem_reg, dvd_reg[mtta_pkg::MAG_W-1]};
    assign trial_diff = trial - {1'b0, t_reg};
    assign ge         = (trial >= {1'b0, t_reg});

    assign q_sat   = dvd_reg[16] ? 16'hFFFF : dvd_reg[15:0];
    assign acc_new = pos_reg ? mtta_pkg::ACC_W'({1'b0, rem_reg})
                             : mtta_pkg::ACC_W'(-{1'b0, rem_reg});

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_type_reg <= mtta_pkg::MATCH_TYPE_RST;
            threshold_reg  <= mtta_pkg::THRESHOLD_RST;
            axis_count_reg <= '0;
            for (int a = 0; a < mtta_pkg::MAX_AXES; a++) axis_code_reg[a] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mtta_pkg::REG_MATCH_TYPE:    match_type_reg   <= cfg_data;
                mtta_pkg::REG_TAP_THRESHOLD: threshold_reg    <= cfg_data;
                mtta_pkg::REG_AXIS_COUNT:    axis_count_reg   <= cfg_data[mtta_pkg::CNT_W-1:0];
                mtta_pkg::REG_AXIS_CODE_0:   axis_code_reg[0] <= cfg_data;
                mtta_pkg::REG_AXIS_CODE_1:   axis_code_reg[1] <= cfg_data;
                mtta_pkg::REG_AXIS_CODE_2:   axis_code_reg[2] <= cfg_data;
                mtta_pkg::REG_AXIS_CODE_3:   axis_code_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < mtta_pkg::MAX_AXES; a++) acc_reg[a] <= '0;
        end else if (cmd.load_out && hit_reg) begin
            acc_reg[axis_reg] <= acc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            type_reg   <= s_event_type;
            code_reg   <= s_event_code;
            motion_reg <= s_motion;
            dev_reg    <= s_source_device;
        end
        if (cmd.lookup) begin
            hit_reg  <= hit;
            axis_reg <= axis;
            pos_reg  <= pos;
            t_reg    <= (threshold_reg == '0) ? 16'd1 : threshold_reg;
            dvd_reg  <= mag;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            rem_reg  <= ge ? trial_diff[15:0] : trial[15:0];
            dvd_reg  <= {dvd_reg[mtta_pkg::MAG_W-2:0], ge};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.load_out) begin
            consumed_reg   <= hit_reg;
            out_motion_reg <= hit_reg ? 16'sd0 : motion_reg;
            binding_reg    <= (hit_reg && (dvd_reg != '0)) ? {axis_reg, pos_reg} : 3'd0;
            tap_count_reg  <= hit_reg ? q_sat : 16'd0;
            tap_dev_reg    <= hit_reg ? dev_reg : 8'd0;
        end
    end

    assign status.hit      = hit;
    assign status.div_last = (step_reg == mtta_pkg::STEP_W'(mtta_pkg::DIV_STEPS - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_consumed      = consumed_reg;
    assign m_out_motion    = out_motion_reg;
    assign m_binding_index = binding_reg;
    assign m_tap_count     = tap_count_reg;
    assign m_tap_device    = tap_dev_reg;

endmodule

@@ src/motion_to_tap_accumulator.sv @@
`timescale 1ns / 1ps
// Channel   | Direction | Ports
// ----------+-----------+--------------------------------------------------------
// input     | in        | s_valid/s_ready, s_event_type, s_event_code, s_motion,
//           |           | s_source_device
// result    | out       | m_valid/m_ready, m_consumed, m_out_motion,
//           |           | m_binding_index, m_tap_count, m_tap_device
// config    | in        | cfg_valid/cfg_ready, cfg_index, cfg_data
//
// A matched event holds the block through accept, axis lookup, 17 steps of the
// bit-serial divider and output load; m_valid is set by a register at the output load.
// Pass-through skips the divider: accept, axis lookup, output load.
// One event in flight; the next is taken while the previous result waits.
// Synchronous active-low reset restores config, clears accumulators and handshakes.
// A stalled result holds the next event in its output load step until m_ready.

module motion_to_tap_accumulator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mtta_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0]                cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [15:0]                s_event_type,
    input  logic [15:0]                s_event_code,
    input  logic signed [15:0]         s_motion,
    input  logic [7:0]                 s_source_device,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_consumed,
    output logic signed [15:0]         m_out_motion,
    output logic [2:0]                 m_binding_index,
    output logic [15:0]                m_tap_count,
    output logic [7:0]                 m_tap_device
);

    mtta_pkg::ctrl_cmd_t  cmd;
    mtta_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mtta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mtta_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_event_type    (s_event_type),
        .s_event_code    (s_event_code),
        .s_motion        (s_motion),
        .s_source_device (s_source_device),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_consumed      (m_consumed),
        .m_out_motion    (m_out_motion),
        .m_binding_index (m_binding_index),
        .m_tap_count     (m_tap_count),
        .m_tap_device    (m_tap_device)
    );

endmodule

@@ src/mtta_chk.sv @@
`timescale 1ns / 1ps
`include "motion_to_tap_accumulator_macros.svh"

module mtta_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_consumed,
    input logic signed [15:0]         m_out_motion,
    input logic [2:0]                 m_binding_index,
    input logic [15:0]                m_tap_count,
    input logic [7:0]                 m_tap_device
);

    `MTTA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_tap_count) && $stable(m_out_motion), "result beat changed while stalled")

    // one event at a time: no second beat straight after an accept
    `MTTA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input taken while busy")

    `MTTA_ASSERT_NOW(a_pass_clean, m_valid && !m_consumed, m_tap_count == 16'd0 && m_binding_index == 3'd0 && m_tap_device == 8'd0, "pass-through carries tap fields")

    `MTTA_ASSERT_NOW(a_consumed_zero, m_valid && m_consumed, m_out_motion == 16'sd0, "consumed beat keeps its motion")

    `MTTA_ASSERT_NOW(a_no_tap_no_bind, m_valid && m_tap_count == 16'd0, m_binding_index == 3'd0, "binding without taps")

endmodule

bind motion_to_tap_accumulator mtta_chk u_mtta_chk (.*);
